// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HVT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hvt_pkg.sv -----
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants of the 4x4 homogeneous vector transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int NumLanes = 4;
  localparam int VecW     = 32;            // Q16.16 vector component
  localparam int FracW    = 16;
  localparam int CoefW    = 16;            // Q8.8 matrix element
  localparam int CoefFrac = 8;
  localparam int ProdW    = CoefW + VecW;
  localparam int AccW     = ProdW + 2;     // sum of four products
  localparam int RndShift = CoefFrac;      // Q26.24 -> Q26.16
  localparam int RndW     = AccW - RndShift;
  localparam int RowW     = NumLanes * CoefW;
  localparam int OpW      = 3;
  localparam int DivSteps = VecW;          // one quotient bit per stage
  localparam int DivLat   = DivSteps + 1;  // operand stage plus steps

  localparam int LaneX = 0;
  localparam int LaneY = 1;
  localparam int LaneZ = 2;
  localparam int LaneW = 3;

  localparam int UserWz   = 0;
  localparam int UserClip = 1;
  localparam int UserW    = 2;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgFwdRow0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgInvRow0 = CfgIdxW'(NumLanes);

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [VecW-1:0]  vec_t;
  typedef logic signed [RndW-1:0]  rnd_t;

  localparam logic signed [AccW-1:0] HalfLsb = AccW'(1 << (RndShift - 1));
  localparam vec_t OneVec = VecW'(1 << FracW);
  localparam rnd_t OneRnd = RndW'(1 << FracW);
  localparam logic [VecW-1:0] VecMax = {1'b0, {(VecW-1){1'b1}}};
  localparam logic [VecW-1:0] VecMin = {1'b1, {(VecW-1){1'b0}}};

  typedef enum logic [1:0] {
    OpVec4   = 2'd0,
    OpPoint  = 2'd1,
    OpDir    = 2'd2,
    OpNormal = 2'd3
  } op_class_e;

  typedef struct packed {
    logic      vld;
    op_class_e cls;
  } meta_t;

  typedef struct packed {
    logic            clip;
    logic [VecW-1:0] val;
  } sat_t;

  typedef struct packed {
    logic            wz;
    logic            clip;
    logic [VecW-1:0] x;
    logic [VecW-1:0] y;
    logic [VecW-1:0] z;
    logic [VecW-1:0] w;
  } res_t;

  // identity row r: 1.0 in Q8.8 on the diagonal
  function automatic logic [RowW-1:0] row_reset(int r);
    return RowW'(1) << (CoefFrac + CoefW * r);
  endfunction

endpackage

// ----- hdl/hvt_lane.sv -----
// ----------------------------------------------------------------------------
// hvt_lane
// One row dot product: four Q8.8 x Q16.16 products, sum, round to Q26.16.
// ----------------------------------------------------------------------------
module hvt_lane import hvt_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  coef_t coef_i [NumLanes],
  input  vec_t  vec_i  [NumLanes],
  output rnd_t  rnd_o
);

  logic signed [ProdW-1:0] prod_d [NumLanes];
  logic signed [ProdW-1:0] prod_q [NumLanes];
  logic signed [AccW-1:0]  acc;
  rnd_t                    rnd_q;

  always_comb begin
    for (int j = 0; j < NumLanes; j++) begin
      prod_d[j] = coef_i[j] * vec_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // round half up: add half LSB, arithmetic shift is the floor
  always_comb begin
    acc = HalfLsb;
    for (int j = 0; j < NumLanes; j++) begin
      acc = acc + AccW'(prod_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q <= acc[AccW-1:RndShift];
    end
  end

  assign rnd_o = rnd_q;

endmodule

// ----- hdl/hvt_div.sv -----
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider for the perspective divide: (num << 16) / den,
// truncated toward zero and saturated to 32 bits. One quotient bit a stage.
// ----------------------------------------------------------------------------
module hvt_div import hvt_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  rnd_t num_i,
  input  rnd_t den_i,
  output sat_t quo_o
);

  localparam int HiW = RndW - FracW;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [RndW-1:0] rem;
    logic [RndW-1:0] den;
    logic [VecW-1:0] sh;   // numerator low bits in, quotient bits out
  } stage_t;

  stage_t          stg_d [DivLat];
  stage_t          stg_q [DivLat];
  logic [RndW-1:0] num_mag;
  logic [RndW-1:0] den_mag;
  logic [HiW-1:0]  num_hi;
  logic [RndW:0]   trial;
  logic [RndW:0]   diff;
  logic            ge;
  logic            big;
  stage_t          last;

  always_comb begin
    num_mag = num_i[RndW-1] ? RndW'(-num_i) : num_i;
    den_mag = den_i[RndW-1] ? RndW'(-den_i) : den_i;
    num_hi  = num_mag[RndW-1:FracW];
    // quotient of 2**32 or more cannot come through 32 steps
    stg_d[0].neg = num_i[RndW-1] ^ den_i[RndW-1];
    stg_d[0].ovf = RndW'(num_hi) >= den_mag;
    stg_d[0].rem = RndW'(num_hi);
    stg_d[0].den = den_mag;
    stg_d[0].sh  = {num_mag[FracW-1:0], {(VecW-FracW){1'b0}}};
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int k = 1; k < DivLat; k++) begin
      trial = {stg_q[k-1].rem, stg_q[k-1].sh[VecW-1]};
      diff  = trial - {1'b0, stg_q[k-1].den};
      ge    = trial >= {1'b0, stg_q[k-1].den};
      stg_d[k]     = stg_q[k-1];
      stg_d[k].rem = ge ? diff[RndW-1:0] : trial[RndW-1:0];
      stg_d[k].sh  = {stg_q[k-1].sh[VecW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign last = stg_q[DivLat-1];

  always_comb begin
    if (last.neg) begin
      big       = last.ovf || (last.sh > VecMin);
      quo_o.val = big ? VecMin : (~last.sh + VecW'(1));
    end else begin
      big       = last.ovf || last.sh[VecW-1];
      quo_o.val = big ? VecMax : last.sh;
    end
    quo_o.clip = big;
  end

endmodule

// ----- hdl/hvt_merge.sv -----
// ----------------------------------------------------------------------------
// hvt_merge
// Combines the four lane sums: w checks, perspective divide, saturation.
// ----------------------------------------------------------------------------
module hvt_merge import hvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  meta_t meta_i,
  input  rnd_t  rnd_i [NumLanes],
  output logic  res_vld_o,
  output res_t  res_o
);

  typedef struct packed {
    logic            use_div;
    logic            wz;
    logic            clip;
    logic [VecW-1:0] x;
    logic [VecW-1:0] y;
    logic [VecW-1:0] z;
    logic [VecW-1:0] w;
  } dly_t;

  function automatic sat_t sat_rnd(rnd_t v);
    sat_t                  s;
    logic [RndW-VecW:0]    hi;
    hi = v[RndW-1:VecW-1];
    if ((&hi) || !(|hi)) begin
      s.clip = 1'b0;
      s.val  = v[VecW-1:0];
    end else begin
      s.clip = 1'b1;
      s.val  = v[RndW-1] ? VecMin : VecMax;
    end
    return s;
  endfunction

  sat_t              sx, sy, sz, sw;
  logic              is_pt, keep_w, wz;
  dly_t              prep;
  dly_t              dly_q [DivLat];
  logic [DivLat-1:0] vld_q;
  sat_t              quo [LaneW];
  dly_t              last;

  always_comb begin
    sx     = sat_rnd(rnd_i[LaneX]);
    sy     = sat_rnd(rnd_i[LaneY]);
    sz     = sat_rnd(rnd_i[LaneZ]);
    sw     = sat_rnd(rnd_i[LaneW]);
    keep_w = meta_i.cls == OpVec4;
    is_pt  = meta_i.cls == OpPoint;
    wz     = is_pt && (rnd_i[LaneW] == '0);
    prep.use_div = is_pt && !wz && (rnd_i[LaneW] != OneRnd);
    prep.wz      = wz;
    prep.x       = wz ? '0 : sx.val;
    prep.y       = wz ? '0 : sy.val;
    prep.z       = wz ? '0 : sz.val;
    prep.w       = keep_w ? sw.val : '0;
    prep.clip    = (!wz && (sx.clip || sy.clip || sz.clip)) || (keep_w && sw.clip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivLat-2:0], meta_i.vld};
    end
  end

  // bypass line runs beside the dividers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= prep;
      for (int k = 1; k < DivLat; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  for (genvar k = 0; k < LaneW; k++) begin : g_div
    hvt_div u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (rnd_i[k]),
      .den_i (rnd_i[LaneW]),
      .quo_o (quo[k])
    );
  end

  assign last      = dly_q[DivLat-1];
  assign res_vld_o = vld_q[DivLat-1];

  always_comb begin
    res_o.wz = last.wz;
    res_o.w  = last.w;
    if (last.use_div) begin
      res_o.x    = quo[LaneX].val;
      res_o.y    = quo[LaneY].val;
      res_o.z    = quo[LaneZ].val;
      res_o.clip = quo[LaneX].clip || quo[LaneY].clip || quo[LaneZ].clip;
    end else begin
      res_o.x    = last.x;
      res_o.y    = last.y;
      res_o.z    = last.z;
      res_o.clip = last.clip;
    end
  end

endmodule

// ----- hdl/homogeneous_vector_transform_top.sv -----
// ----------------------------------------------------------------------------
// homogeneous_vector_transform_top
// 4x4 Q8.8 matrix times Q16.16 vector: raw, point with divide, direction,
// normal. Four row lanes, then a merge stage with three pipelined dividers.
//
//   channel  dir  payload
//   s_axis   in   tdata {in_w,in_z,in_y,in_x}, tuser opcode
//   m_axis   out  tdata {out_w,out_z,out_y,out_x}, tuser {saturated,w_zero}
//   cfg      in   cfg_idx_i row register 0..7, cfg_data_i 64-bit row
//
// One request per cycle sustained while m_axis does not stall; 36 register
// stages (two lane stages, the 33-stage divider: operand stage plus one
// quotient bit per stage, output register) lie between s_axis and m_axis.
// The whole pipeline advances when the output register is empty or taken;
// a one-entry skid buffer keeps s_axis_tready registered.
// Reset loads identity into both matrices and empties the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module homogeneous_vector_transform_top import hvt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [NumLanes*VecW-1:0] s_axis_tdata,  // in_x, in_y, in_z, in_w
  input  logic [OpW-1:0]        s_axis_tuser,     // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [NumLanes*VecW-1:0] m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic [UserW-1:0]      m_axis_tuser,     // w_zero, saturated
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [RowW-1:0]       cfg_data_i
);

  logic [NumLanes-1:0][RowW-1:0] fwd_q, inv_q;

  logic                     en;
  logic                     s_acc;
  logic                     skid_vld_q;
  logic [NumLanes*VecW-1:0] skid_data_q;
  logic [OpW-1:0]           skid_op_q;
  logic                     in_vld;
  logic [NumLanes*VecW-1:0] in_data;
  logic [OpW-1:0]           in_op;
  op_class_e                cls;
  logic                     use_inv;
  vec_t                     vec_sel [NumLanes];
  rnd_t                     rnd [NumLanes];
  meta_t                    meta_p_q, meta_r_q;
  logic                     res_vld;
  res_t                     res;
  logic                     out_vld_q;
  res_t                     out_q;

  // configuration rows
  for (genvar r = 0; r < NumLanes; r++) begin : g_row
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fwd_q[r] <= row_reset(r);
        inv_q[r] <= row_reset(r);
      end else if (cfg_we_i) begin
        if (cfg_idx_i == CfgFwdRow0 + CfgIdxW'(r)) begin
          fwd_q[r] <= cfg_data_i;
        end
        if (cfg_idx_i == CfgInvRow0 + CfgIdxW'(r)) begin
          inv_q[r] <= cfg_data_i;
        end
      end
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !skid_vld_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // skid: catches a request taken while the pipeline is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (en) begin
        skid_vld_q <= 1'b0;
      end
    end else if (s_acc && !en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && !en) begin
      skid_data_q <= s_axis_tdata;
      skid_op_q   <= s_axis_tuser;
    end
  end

  assign in_vld  = skid_vld_q || s_acc;
  assign in_data = skid_vld_q ? skid_data_q : s_axis_tdata;
  assign in_op   = skid_vld_q ? skid_op_q : s_axis_tuser;
  assign cls     = op_class_e'(in_op[OpW-1:1]);
  assign use_inv = in_op[0];

  always_comb begin
    for (int j = 0; j < LaneW; j++) begin
      vec_sel[j] = in_data[j*VecW +: VecW];
    end
    // points take w = 1.0; direction and normal mask the fourth column
    vec_sel[LaneW] = (cls == OpVec4) ? in_data[LaneW*VecW +: VecW] : OneVec;
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    coef_t coef_l [NumLanes];

    always_comb begin
      for (int j = 0; j < NumLanes; j++) begin
        case (cls)
          OpNormal: begin
            coef_l[j] = use_inv ? fwd_q[j][i*CoefW +: CoefW] : inv_q[j][i*CoefW +: CoefW];
          end
          default: begin
            coef_l[j] = use_inv ? inv_q[i][j*CoefW +: CoefW] : fwd_q[i][j*CoefW +: CoefW];
          end
        endcase
        if ((cls inside {OpDir, OpNormal}) && (i == LaneW || j == LaneW)) begin
          coef_l[j] = '0;
        end
      end
    end

    hvt_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef_l),
      .vec_i  (vec_sel),
      .rnd_o  (rnd[i])
    );
  end

  // request class follows the lane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_p_q <= '{vld: 1'b0, cls: OpVec4};
      meta_r_q <= '{vld: 1'b0, cls: OpVec4};
    end else if (en) begin
      meta_p_q <= '{vld: in_vld, cls: cls};
      meta_r_q <= meta_p_q;
    end
  end

  hvt_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .meta_i    (meta_r_q),
    .rnd_i     (rnd),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.w, out_q.z, out_q.y, out_q.x};
  assign m_axis_tuser  = {out_q.clip, out_q.wz};

  `HVT_ASSERT_IMPL(a_wz_clean, m_axis_tvalid && m_axis_tuser[UserWz], (m_axis_tdata[LaneW*VecW-1:0] == '0) && !m_axis_tuser[UserClip], "w_zero result carries nonzero xyz or clip")
  `HVT_ASSERT_NEXT(a_skid_hold, skid_vld_q && !en, skid_vld_q && $stable(skid_data_q), "skid entry lost during stall")
  `HVT_ASSERT_IMPL(a_skid_fill, $rose(skid_vld_q), $past(s_axis_tvalid) && !$past(en), "skid filled without a stalled request")

endmodule

// ----- verif/tb_homogeneous_vector_transform_top.sv -----
// ----------------------------------------------------------------------------
// tb_homogeneous_vector_transform_top
// Self-checking bench for the 4x4 Q8.8 matrix / Q16.16 vector transform.
// A driver streams vector requests and a monitor predicts each transform
// from a local copy of both matrices at acceptance, then checks every
// output beat in order. Matrices are reloaded between phases while the
// pipeline is empty; handshake gaps, stalls and one long output hold vary.
// ----------------------------------------------------------------------------
module tb_homogeneous_vector_transform_top;
  import hvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NumPhases   = 10;
  localparam int     PhaseItems  = 125;
  localparam int     HoldAt      = 60;   // accepted requests before long hold
  localparam int     HoldLen     = 200;
  localparam int     MaxReports  = 10;
  localparam longint OneQ16      = 1 << FracW;
  localparam longint RoundHalf   = 1 << (CoefFrac - 1);

  typedef struct {
    logic [OpW-1:0] op;
    vec_t           x;
    vec_t           y;
    vec_t           z;
    vec_t           w;
  } vec_req_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [NumLanes*VecW-1:0] s_axis_tdata  = '0;  // in_x, in_y, in_z, in_w
  logic [OpW-1:0]           s_axis_tuser  = '0;  // opcode
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [NumLanes*VecW-1:0] m_axis_tdata;        // out_x, out_y, out_z, out_w
  logic [UserW-1:0]         m_axis_tuser;        // w_zero, saturated
  logic                     cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i     = '0;
  logic [RowW-1:0]          cfg_data_i    = '0;

  // local copy of the matrix rows as last written
  logic [RowW-1:0] fwd_m [NumLanes];
  logic [RowW-1:0] inv_m [NumLanes];

  vec_req_t pending_vecs[$];
  res_t     expected_xforms[$];

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  logic rx_hold  = 1'b0;
  int   tx_gap_max   = 0;
  int   rx_stall_max = 0;
  int   tx_gap       = 0;
  int   rx_wait      = 0;
  int   hold_left    = 0;
  bit   hold_done    = 1'b0;
  int   accepted_cnt = 0;
  int   checked_cnt  = 0;
  int   err_cnt      = 0;
  int   settings_cnt = 0;

  homogeneous_vector_transform_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Transform predictor
  // ---------------------------------------------------------------------------
  function automatic longint coef_at(logic [RowW-1:0] row, int c);
    coef_t e;
    e = row[CoefW*c +: CoefW];
    return e;
  endfunction

  function automatic vec_t clip32(longint v, ref logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return VecMax;
    end else if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return VecMin;
    end
    return vec_t'(v);
  endfunction

  function automatic res_t predict_transform(vec_req_t rq);
    longint          v [NumLanes];
    longint          r [NumLanes];
    longint          acc;
    logic [RowW-1:0] m [NumLanes];
    op_class_e       cls;
    int              n;
    bit              tr;
    logic            clip;
    res_t            res;

    cls = op_class_e'(rq.op[OpW-1:1]);
    tr  = (cls == OpNormal);
    n   = (cls == OpVec4 || cls == OpPoint) ? 4 : 3;
    // normals take the transpose of the other matrix
    for (int k = 0; k < NumLanes; k++)
      m[k] = (rq.op[0] ^ tr) ? inv_m[k] : fwd_m[k];
    v[LaneX] = rq.x;
    v[LaneY] = rq.y;
    v[LaneZ] = rq.z;
    v[LaneW] = (cls == OpPoint) ? OneQ16 : longint'(rq.w);

    for (int i = 0; i < NumLanes; i++) begin
      acc = 0;
      if (i < n) begin
        for (int j = 0; j < n; j++)
          acc += coef_at(tr ? m[j] : m[i], tr ? i : j) * v[j];
      end
      r[i] = (acc + RoundHalf) >>> CoefFrac;  // floor, ties go up
    end

    res.wz = 1'b0;
    if (cls == OpPoint) begin
      if (r[LaneW] == 0) begin
        res.wz = 1'b1;
        for (int k = 0; k < 3; k++) r[k] = 0;
      end else if (r[LaneW] != OneQ16) begin
        for (int k = 0; k < 3; k++) r[k] = (r[k] * OneQ16) / r[LaneW];
      end
      r[LaneW] = 0;
    end

    clip  = 1'b0;
    res.x = clip32(r[LaneX], clip);
    res.y = clip32(r[LaneY], clip);
    res.z = clip32(r[LaneZ], clip);
    res.w = clip32(r[LaneW], clip);
    res.clip = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver, output monitor, receiver
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    vec_req_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (s_axis_tvalid) tx_gap = $urandom_range(0, tx_gap_max);
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_vecs.size() != 0) begin
        nxt = pending_vecs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.w, nxt.z, nxt.y, nxt.x};
        s_axis_tuser  <= nxt.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    vec_req_t rq;
    res_t     exp_r;
    res_t     got_r;
    in_fire  <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      rq.op = s_axis_tuser;
      rq.x  = s_axis_tdata[LaneX*VecW +: VecW];
      rq.y  = s_axis_tdata[LaneY*VecW +: VecW];
      rq.z  = s_axis_tdata[LaneZ*VecW +: VecW];
      rq.w  = s_axis_tdata[LaneW*VecW +: VecW];
      expected_xforms.push_back(predict_transform(rq));
      accepted_cnt++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.x    = m_axis_tdata[LaneX*VecW +: VecW];
      got_r.y    = m_axis_tdata[LaneY*VecW +: VecW];
      got_r.z    = m_axis_tdata[LaneZ*VecW +: VecW];
      got_r.w    = m_axis_tdata[LaneW*VecW +: VecW];
      got_r.wz   = m_axis_tuser[UserWz];
      got_r.clip = m_axis_tuser[UserClip];
      if (expected_xforms.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: unexpected result x=%h y=%h z=%h w=%h wz=%b sat=%b", $realtime,
                   got_r.x, got_r.y, got_r.z, got_r.w, got_r.wz, got_r.clip);
      end else begin
        exp_r = expected_xforms.pop_front();
        checked_cnt++;
        if (got_r.x !== exp_r.x || got_r.y !== exp_r.y || got_r.z !== exp_r.z ||
            got_r.w !== exp_r.w || got_r.wz !== exp_r.wz || got_r.clip !== exp_r.clip) begin
          err_cnt++;
          if (err_cnt <= MaxReports) begin
            $display("%0t: mismatch on result %0d", $realtime, checked_cnt);
            $display("  exp x=%h y=%h z=%h w=%h wz=%b sat=%b",
                     exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.wz, exp_r.clip);
            $display("  got x=%h y=%h z=%h w=%h wz=%b sat=%b",
                     got_r.x, got_r.y, got_r.z, got_r.w, got_r.wz, got_r.clip);
          end
        end
      end
    end
  end

  // one long output hold while the sender keeps streaming
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && accepted_cnt >= HoldAt) begin
      hold_left = HoldLen;
      hold_done = 1'b1;
    end
    rx_hold <= (hold_left > 0);
  end

  always @(negedge clk_i) begin
    if (out_fire) rx_wait = $urandom_range(0, rx_stall_max);
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_vecs.size() != 0 || s_axis_tvalid || expected_xforms.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic load_matrices(input logic [RowW-1:0] fwd_rows [NumLanes],
                               input logic [RowW-1:0] inv_rows [NumLanes]);
    for (int r = 0; r < NumLanes; r++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgFwdRow0 + CfgIdxW'(r);
      cfg_data_i <= fwd_rows[r];
      fwd_m[r]    = fwd_rows[r];
      @(negedge clk_i);
      cfg_idx_i  <= CfgInvRow0 + CfgIdxW'(r);
      cfg_data_i <= inv_rows[r];
      inv_m[r]    = inv_rows[r];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  task automatic set_pace(int tx_max, int rx_max);
    @(posedge clk_i);
    tx_gap_max   = tx_max;
    rx_stall_max = rx_max;
  endtask

  task automatic queue_vec(logic [OpW-1:0] op, vec_t x, vec_t y, vec_t z, vec_t w);
    vec_req_t rq;
    rq.op = op;
    rq.x  = x;
    rq.y  = y;
    rq.z  = z;
    rq.w  = w;
    pending_vecs.push_back(rq);
  endtask

  function automatic coef_t rand_coef();
    coef_t specials [6] = '{16'h0000, 16'h0100, 16'hff00, 16'h7fff, 16'h8000, 16'h0001};
    case ($urandom_range(0, 3))
      0:       return coef_t'($urandom());
      1:       return specials[$urandom_range(0, 5)];
      default: return coef_t'($urandom_range(0, 1024) - 512);  // within +/-2.0
    endcase
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  // bottom row: mostly affine or perspective-like so points reach every w path
  function automatic logic [RowW-1:0] rand_w_row();
    case ($urandom_range(0, 2))
      0:       return 64'h0100 << (CoefW*LaneW);
      1:       return rand_row();
      default: return {16'h0100, rand_coef(), rand_coef(), rand_coef()};
    endcase
  endfunction

  function automatic vec_t rand_comp();
    vec_t specials [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                           32'h0001_0000, 32'hffff_0000, 32'h0000_0001};
    case ($urandom_range(0, 2))
      0:       return vec_t'($urandom());
      1:       return specials[$urandom_range(0, 5)];
      default: return vec_t'($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [RowW-1:0] fr [NumLanes];
    logic [RowW-1:0] ir [NumLanes];

    for (int r = 0; r < NumLanes; r++) begin
      fwd_m[r] = 64'h0100 << (CoefW*r);
      inv_m[r] = 64'h0100 << (CoefW*r);
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity after reset: every opcode, then full-scale vectors
    set_pace(3, 3);
    for (int op = 0; op < 8; op++)
      queue_vec(OpW'(op), 32'h0001_8000, 32'hfffd_c000, 32'h0003_0000, 32'h0000_8000);
    queue_vec(3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_vec(3'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    wait_idle();

    // extreme rows force clipping; w=2 divides, zero bottom row of I gives w=0
    fr = '{64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000,
           64'h0000_0000_0000_0100, 64'h0200_0000_0000_0000};
    ir = '{64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
           64'h0000_0100_0000_0000, 64'h0000_0000_0000_0000};
    load_matrices(fr, ir);
    set_pace(3, 3);
    queue_vec(3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_vec(3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vec(3'd2, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0);
    queue_vec(3'd2, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h0);
    queue_vec(3'd3, 32'h0005_0000, 32'hfffb_0000, 32'h0001_0000, 32'h0);
    queue_vec(3'd4, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
    queue_vec(3'd5, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
    queue_vec(3'd6, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0080, 32'h0);
    queue_vec(3'd7, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    wait_idle();

    // tiny w amplifies the divide; w=-1 negates, overflowing the minimum
    fr[LaneW] = 64'h0001_0000_0000_0000;
    ir[LaneW] = 64'hff00_0000_0000_0000;
    load_matrices(fr, ir);
    set_pace(3, 3);
    queue_vec(3'd2, 32'h0002_0000, 32'hffff_0000, 32'h0, 32'h0);
    queue_vec(3'd2, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
    queue_vec(3'd3, 32'h0003_0000, 32'hfffe_8000, 32'h0, 32'h0);
    queue_vec(3'd3, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int r = 0; r < NumLanes; r++) begin
        fr[r] = (r == LaneW) ? rand_w_row() : rand_row();
        ir[r] = (r == LaneW) ? rand_w_row() : rand_row();
      end
      if (ph == 1) begin
        fr = '{default: 64'h7fff_7fff_7fff_7fff};
        ir = '{default: 64'h8000_8000_8000_8000};
      end else if (ph == 2) begin
        fr = '{default: 64'h0};
      end else if (ph == 5) begin
        for (int r = 0; r < NumLanes; r++) fr[r] = 64'h0100 << (CoefW*r);
      end
      load_matrices(fr, ir);
      case (ph % 4)
        0:       set_pace(0, 0);
        1:       set_pace(3, 3);
        2:       set_pace(0, 3);
        default: set_pace(3, 0);
      endcase
      for (int k = 0; k < PhaseItems; k++)
        queue_vec(OpW'($urandom_range(0, 7)), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp());
      wait_idle();
    end

    repeat (40) @(negedge clk_i);
    $display("Checked %0d transforms over all opcodes under %0d matrix settings,",
             checked_cnt, settings_cnt);
    $display("with 0-3 cycle gaps/stalls and a %0d-cycle output hold.", HoldLen);
    if (err_cnt == 0 && expected_xforms.size() == 0) begin
      $display("homogeneous_vector_transform_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_cnt, expected_xforms.size());
      $display("homogeneous_vector_transform_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d requests accepted, %0d results checked", accepted_cnt,
             checked_cnt);
    $display("homogeneous_vector_transform_top verification failed");
    $finish;
  end

endmodule

// ----- homogeneous_vector_transform_top.f -----
+incdir+hdl
hdl/hvt_pkg.sv
hdl/hvt_lane.sv
hdl/hvt_div.sv
hdl/hvt_merge.sv
hdl/homogeneous_vector_transform_top.sv
verif/tb_homogeneous_vector_transform_top.sv
